// ----- rtl/core/tsmw_pkg.sv -----
// Shared types and constants of the three-axis windowed mean block.
package tsmw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int BYTE_W   = 8;
  localparam int NUM_AXES = 3;
  localparam int CFG_IDX_W = 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_READY_MASK    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_MASK = 1'b1;

  localparam logic [BYTE_W-1:0] READY_MASK_RST    = 8'h01;
  localparam logic [BYTE_W-1:0] OVERFLOW_MASK_RST = 8'h08;

  // Per-lane strobes from the pipeline control.
  typedef struct packed {
    logic rd_en;
    logic upd_en;
    logic wr_zero;
  } lane_ctl_t;

endpackage

// ----- rtl/core/tsmw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tsmw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/tsmw_lane.sv -----
// One axis lane: sample window memory, running sum and mean by reciprocal multiply.
module tsmw_lane import tsmw_pkg::*; #(
  parameter int WINDOW_SIZE = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lane_ctl_t                      ctl,
  input  logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
  input  logic [$clog2(WINDOW_SIZE)-1:0] wr_addr,
  input  sample_t                        sample_in,
  output sample_t                        mean_out
);

  localparam int ADDR_W  = $clog2(WINDOW_SIZE);
  localparam int SUM_W   = SAMPLE_W + ADDR_W;
  localparam int SHIFT   = SUM_W + ADDR_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));

  logic [SUM_W-1:0]    sum_r, sum_nxt;
  sample_t             old_sample;
  logic [SAMPLE_W-1:0] wdata;
  logic                neg;
  logic [SUM_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W:0]   quo;

  assign wdata = ctl.wr_zero ? '0 : sample_in;

  tsmw_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.upd_en | ctl.wr_zero),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (old_sample)
  );

  // Drop the oldest sample of the slot, add the new one.
  assign sum_nxt = sum_r
                 - {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample}
                 + {{(SUM_W-SAMPLE_W){sample_in[SAMPLE_W-1]}}, sample_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.upd_en) begin
      sum_r <= sum_nxt;
    end
  end

  // Divide the magnitude by the window size, then restore the sign (truncates toward zero).
  assign neg  = sum_r[SUM_W-1];
  assign mag  = neg ? (~sum_r + 1'b1) : sum_r;
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);
  assign quo  = prod[SHIFT +: SAMPLE_W+1];

  assign mean_out = neg ? SAMPLE_W'(~quo + 1'b1) : SAMPLE_W'(quo);

endmodule

// ----- rtl/core/three_axis_sample_window_mean.sv -----
// Top level of the three-axis windowed mean block: ring pipeline, lanes and result merge.
// Takes one raw three-axis reading per item and returns one result per item: the
// per-axis mean over the last WINDOW_SIZE stored samples (truncated toward zero) and a
// status in out_tuser. Sustained rate is one item per clock while out_tready is high; a
// result passes stage 1, stage 2 and the output register. The rate is set by the per-lane ring
// memory, which takes one read (at accept) and one write (when the item leaves stage 1) per item.
// After reset the block runs a clearing pass over all WINDOW_SIZE slots of the ring memory,
// holding in_tready low; configuration writes are taken at any time.
module three_axis_sample_window_mean import tsmw_pkg::*; #(
  parameter int WINDOW_SIZE = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // status_one[7:0], x_low_byte[15:8], x_high_byte[23:16], y_low_byte[31:24],
  // y_high_byte[39:32], z_low_byte[47:40], z_high_byte[55:48], status_two[63:56]
  input  logic [63:0]          in_tdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // mean_x[15:0], mean_y[31:16], mean_z[47:32]
  output logic [47:0]          out_tdata,
  // result_status[1:0]
  output logic [1:0]           out_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(WINDOW_SIZE);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_SIZE - 1);

  logic [BYTE_W-1:0] ready_mask_r, overflow_mask_r;
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] slot_r;

  logic              s1_valid_r, s1_ready_r;
  status_t           s1_status_r;
  logic [ADDR_W-1:0] s1_slot_r;
  sample_t           s1_sample_r [NUM_AXES];

  logic              s2_valid_r;
  status_t           s2_status_r;

  logic              out_valid_r;
  logic [47:0]       out_data_r;
  status_t           out_status_r;

  logic              acc, out_adv, s2_free, s1_free, s1_adv, s2_adv;
  logic              item_ready;
  status_t           item_status;
  lane_ctl_t         lane_ctl;
  logic [ADDR_W-1:0] wr_addr;
  sample_t           lane_mean [NUM_AXES];
  sample_t           new_sample [NUM_AXES];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_mask_r    <= READY_MASK_RST;
      overflow_mask_r <= OVERFLOW_MASK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_READY_MASK:    ready_mask_r    <= cfg_data;
        CFG_OVERFLOW_MASK: overflow_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_adv   = !out_valid_r || out_tready;
  assign s2_free   = !s2_valid_r || out_adv;
  assign s2_adv    = s2_valid_r && out_adv;
  assign s1_free   = !s1_valid_r || s2_free;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_tready = !clearing_r && s1_free;
  assign acc       = in_tvalid && in_tready;

  // Classify the item at accept.
  assign item_ready = |(in_tdata[7:0] & ready_mask_r);
  always_comb begin
    if (!item_ready) begin
      item_status = ST_NOT_READY;
    end else if (|(in_tdata[63:56] & overflow_mask_r)) begin
      item_status = ST_OVERFLOW;
    end else begin
      item_status = ST_OK;
    end
  end

  assign new_sample[0] = in_tdata[23:8];
  assign new_sample[1] = in_tdata[39:24];
  assign new_sample[2] = in_tdata[55:40];

  // Clearing pass and write slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      slot_r     <= '0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_SLOT) begin
          clearing_r <= 1'b0;
        end
      end
      if (acc) begin
        slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
      end
    end
  end

  // Stage 1: ring read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ready_r  <= item_ready;
      s1_status_r <= item_status;
      s1_slot_r   <= slot_r;
      for (int i = 0; i < NUM_AXES; i++) begin
        s1_sample_r[i] <= new_sample[i];
      end
    end
  end

  assign lane_ctl.rd_en   = acc;
  assign lane_ctl.upd_en  = s1_adv && s1_ready_r;
  assign lane_ctl.wr_zero = clearing_r;
  assign wr_addr          = clearing_r ? clr_cnt_r : s1_slot_r;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    tsmw_lane #(
      .WINDOW_SIZE (WINDOW_SIZE)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (lane_ctl),
      .rd_addr   (slot_r),
      .wr_addr   (wr_addr),
      .sample_in (s1_sample_r[g]),
      .mean_out  (lane_mean[g])
    );
  end

  // Stage 2: sums updated, means forming
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_status_r <= s1_status_r;
    end
  end

  // Merge the lane means with the status into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_data_r   <= {lane_mean[2], lane_mean[1], lane_mean[0]};
      out_status_r <= s2_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

// ----- rtl/core/tsmw_checker.sv -----
// Port-level checker of the three-axis windowed mean block, with its bind.
module tsmw_checker import tsmw_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [47:0]          out_tdata,
  input logic [1:0]           out_tuser,
  input logic                 out_tvalid,
  input logic                 out_tready
);

  logic [47:0] prev_means_r;
  logic [2:0]  pending_r;
  logic        in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Track the last delivered means and the items in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_means_r <= '0;
      pending_r    <= '0;
    end else begin
      if (out_acc) begin
        prev_means_r <= out_tdata;
      end
      pending_r <= pending_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during clearing pass");

  a_not_ready_keeps_means: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_NOT_READY |-> out_tdata == prev_means_r)
    else $error("not-ready item changed the window means");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != 3'd0)
    else $error("result item without an accepted input item");

  a_bounded_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd3)
    else $error("too many items in flight");

endmodule

bind three_axis_sample_window_mean tsmw_checker u_tsmw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
